@@ hdl/dsmcc_pkg.sv @@
// Shared types and constants for the dual-slot memory card controller.
// Holds register codes, control bits and card geometry defaults.
// No dependencies.
package dsmcc_pkg;

    // Default card size in bytes, per slot
    localparam int CARD_BYTES = 131072;
    // Both cards share one byte store
    localparam int CARD_DEPTH = 2 * CARD_BYTES;

    localparam int DATA_W = 32;
    localparam int NUM_REGS = 8;

    // Erase acts on the 64 KiB block that holds the address
    localparam int          ERASE_SPAN_W    = 16;
    localparam logic [31:0] ERASE_BASE_MASK = 32'h0000_FFFF;
    localparam logic [7:0]  ERASE_FILL      = 8'hFF;

    // Action bits of the control register
    localparam int CTL_STORE = 0;
    localparam int CTL_LOAD  = 1;
    localparam int CTL_ERASE = 2;
    localparam int CTL_W     = 3;

    typedef enum logic [1:0] {
        REG_CTL   = 2'd0,
        REG_ADDR  = 2'd1,
        REG_DATA  = 2'd2,
        REG_READY = 2'd3
    } t_reg_sel;

    typedef enum logic {
        MODE_READ  = 1'b0,
        MODE_WRITE = 1'b1
    } t_mode;

endpackage

@@ hdl/dsmcc_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Default depth taken from dsmcc_pkg.
module dsmcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dsmcc_pkg::CARD_DEPTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/dual_slot_memory_card_controller.sv @@
// Top level of the dual-slot memory card controller.
// Depends on dsmcc_pkg and dsmcc_ram (byte store for both cards).
//
// Usage:
//   Command channel: drive i_mode, i_slot, i_reg_select, i_write_data and
//   i_write_mask and raise start; the item is taken at a clock edge where
//   start is high and busy is low. Each item gives one result on
//   o_read_data, marked by o_strobe for exactly one cycle; the receiver
//   cannot hold it off. A read returns the addressed register, a write
//   returns zero.
//   Timing: a register read, a plain register write, or a control write
//   with no action bits strobes in the cycle after acceptance and busy stays
//   low, so such items run one per cycle. A control write with action bits
//   holds busy high while it reduces the address modulo the card size
//   (S_ADDR, S_MOD), plans the first action (S_PLAN), runs the actions in
//   erase, store, load order and finishes (S_FIN). A store writes 4 bytes
//   and plans again; a load issues 4 byte reads, then collects the word;
//   an erase writes one byte of the store per cycle to the end of its 64 KiB
//   block or of the card and plans again. The result strobes in the first
//   cycle with busy low. The byte store's single write/read port paces this.
//   Reset: all slot registers clear at once; then a clearing pass zeroes
//   all 2 * CARD_BYTES bytes of the byte store, with busy high, before the
//   first item is taken.
module dual_slot_memory_card_controller #(
    parameter int CARD_BYTES = dsmcc_pkg::CARD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_mode,
    input  logic        i_slot,
    input  logic [1:0]  i_reg_select,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_write_mask,
    output logic        o_strobe,
    output logic [31:0] o_read_data
);

    // Card address width, store depth and store address width
    localparam int CAW   = $clog2(CARD_BYTES);
    localparam int DEPTH = 2 * CARD_BYTES;
    localparam int MAW   = $clog2(DEPTH);

    localparam logic [CAW-1:0] LAST_BYTE = CAW'(CARD_BYTES - 1);
    localparam logic [MAW-1:0] LAST_CLR  = MAW'(DEPTH - 1);
    localparam logic [MAW-1:0] SLOT1_BASE = MAW'(CARD_BYTES);
    localparam logic [CAW:0]   CARD_SIZE_W = (CAW + 1)'(CARD_BYTES);
    localparam logic [CAW-1:0] ERASE_MASK  = CAW'(dsmcc_pkg::ERASE_BASE_MASK);
    localparam logic [dsmcc_pkg::ERASE_SPAN_W-1:0] ERASE_LAST = '1;
    // floor(2^32 / CARD_BYTES); at most 2^16, so 17 bits
    localparam logic [16:0]    RECIP = 17'((64'd1 << 32) / 64'(CARD_BYTES));

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_MOD,
        S_PLAN,
        S_ERASE,
        S_STORE,
        S_LOAD,
        S_LOAD_END,
        S_FIN
    } t_state;

    // Pick the next card action from the bits still pending, in model order
    function automatic t_state next_phase(input logic [dsmcc_pkg::CTL_W-1:0] pend);
        t_state nxt;
        priority if (pend[dsmcc_pkg::CTL_ERASE]) begin
            nxt = S_ERASE;
        end else if (pend[dsmcc_pkg::CTL_STORE]) begin
            nxt = S_STORE;
        end else if (pend[dsmcc_pkg::CTL_LOAD]) begin
            nxt = S_LOAD;
        end else begin
            nxt = S_FIN;
        end
        return nxt;
    endfunction

    t_state                          r_state;
    logic [31:0]                     r_regs [dsmcc_pkg::NUM_REGS];
    logic                            r_slot;
    logic [dsmcc_pkg::CTL_W-1:0]     r_ctl;
    logic [16:0]                     r_quot;
    logic [CAW-1:0]                  r_addr;
    logic [CAW-1:0]                  r_ptr;
    logic [dsmcc_pkg::ERASE_SPAN_W-1:0] r_cnt;
    logic [1:0]                      r_byte;
    logic [7:0]                      r_word [3];
    logic [MAW-1:0]                  r_clr;
    logic                            r_strobe;
    logic [31:0]                     r_read_data;

    logic [2:0]     in_idx;
    logic [31:0]    n_merged;
    logic [31:0]    addr_reg;
    logic [31:0]    data_reg;
    logic [48:0]    quot_prod;
    logic [31:0]    quot_times;
    logic [31:0]    rem_wide;
    logic [CAW:0]   rem_est;
    logic [CAW:0]   n_addr;
    logic [CAW-1:0] ptr_inc;
    logic [CAW-1:0] erase_start;
    logic [MAW-1:0] card_addr;

    logic           ram_we;
    logic [MAW-1:0] ram_waddr;
    logic [7:0]     ram_wdata;
    logic [7:0]     ram_rdata;

    assign in_idx   = {i_slot, i_reg_select};
    assign n_merged = (r_regs[in_idx] & ~i_write_mask) | (i_write_data & i_write_mask);
    assign addr_reg = r_regs[{r_slot, dsmcc_pkg::REG_ADDR}];
    assign data_reg = r_regs[{r_slot, dsmcc_pkg::REG_DATA}];

    // Reduce the address register modulo the card size: a reciprocal multiply
    // estimates the quotient (low by at most one), then one conditional
    // subtract corrects the remainder
    assign quot_prod  = {17'd0, addr_reg} * {32'd0, RECIP};
    assign quot_times = 32'(r_quot) * 32'(CARD_BYTES);
    assign rem_wide   = addr_reg - quot_times;
    assign rem_est    = rem_wide[CAW:0];
    assign n_addr     = (rem_est >= CARD_SIZE_W) ? rem_est - CARD_SIZE_W : rem_est;

    // Byte pointer wraps at the end of the card
    assign ptr_inc     = (r_ptr == LAST_BYTE) ? '0 : r_ptr + 1'b1;
    assign erase_start = r_addr & ~ERASE_MASK;
    assign card_addr   = (r_slot ? SLOT1_BASE : '0) + MAW'(r_ptr);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = card_addr;
        ram_wdata = data_reg[{r_byte, 3'b000} +: 8];
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
            end
            S_ERASE: begin
                ram_we    = 1'b1;
                ram_wdata = dsmcc_pkg::ERASE_FILL;
            end
            S_STORE: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    dsmcc_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_card_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (card_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
            r_regs   <= '{default: '0};
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    // Zero the byte store, one entry per cycle
                    if (r_clr == LAST_CLR) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr <= r_clr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_slot <= i_slot;
                        if (i_mode == dsmcc_pkg::MODE_READ) begin
                            r_read_data <= r_regs[in_idx];
                            r_strobe    <= 1'b1;
                        end else begin
                            r_read_data    <= '0;
                            r_regs[in_idx] <= n_merged;
                            if (i_reg_select == dsmcc_pkg::REG_CTL &&
                                n_merged[dsmcc_pkg::CTL_W-1:0] != '0) begin
                                // Card action: reduce the address first
                                r_ctl   <= n_merged[dsmcc_pkg::CTL_W-1:0];
                                r_state <= S_ADDR;
                            end else begin
                                if (i_reg_select == dsmcc_pkg::REG_CTL) begin
                                    r_regs[{i_slot, dsmcc_pkg::REG_READY}] <= 32'd1;
                                end
                                r_strobe <= 1'b1;
                            end
                        end
                    end
                end
                S_ADDR: begin
                    // Hold the quotient estimate for the correction cycle
                    r_quot  <= quot_prod[48:32];
                    r_state <= S_MOD;
                end
                S_MOD: begin
                    r_addr  <= n_addr[CAW-1:0];
                    r_state <= S_PLAN;
                end
                S_PLAN: begin
                    r_state <= next_phase(r_ctl);
                    r_ptr   <= r_ctl[dsmcc_pkg::CTL_ERASE] ? erase_start : r_addr;
                    r_byte  <= '0;
                    r_cnt   <= '0;
                end
                S_ERASE: begin
                    // Stop at the end of the 64 KiB block or of the card
                    if (r_cnt == ERASE_LAST || r_ptr == LAST_BYTE) begin
                        r_ctl[dsmcc_pkg::CTL_ERASE] <= 1'b0;
                        r_state <= S_PLAN;
                    end else begin
                        r_ptr <= r_ptr + 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_STORE: begin
                    r_ptr  <= ptr_inc;
                    r_byte <= r_byte + 1'b1;
                    if (r_byte == 2'd3) begin
                        r_ctl[dsmcc_pkg::CTL_STORE] <= 1'b0;
                        r_state <= S_PLAN;
                    end
                end
                S_LOAD: begin
                    // Issue one byte read per cycle; each byte comes back through the store's registered read
                    r_ptr  <= ptr_inc;
                    r_byte <= r_byte + 1'b1;
                    if (r_byte != 2'd0) begin
                        r_word[r_byte - 2'd1] <= ram_rdata;
                    end
                    if (r_byte == 2'd3) begin
                        r_state <= S_LOAD_END;
                    end
                end
                S_LOAD_END: begin
                    r_regs[{r_slot, dsmcc_pkg::REG_DATA}] <=
                        {ram_rdata, r_word[2], r_word[1], r_word[0]};
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    r_regs[{r_slot, dsmcc_pkg::REG_READY}] <= 32'd1;
                    r_strobe <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (r_state != S_IDLE);
    assign o_strobe    = r_strobe;
    assign o_read_data = r_read_data;

    // A register read strobes in the next cycle
    a_read_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == dsmcc_pkg::MODE_READ) |=> o_strobe)
        else $error("read item did not strobe after one cycle");

    // A write item loads a zero result when it is taken
    a_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_mode == dsmcc_pkg::MODE_WRITE) |=> (o_read_data == '0))
        else $error("write item result is not zero");

    // Finishing a card action strobes and frees the port
    a_fin_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (o_strobe && !busy))
        else $error("card action finished without strobe");

    // The store is written only while clearing, erasing or storing
    a_we_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_CLEAR || r_state == S_ERASE || r_state == S_STORE))
        else $error("store written outside a write phase");

    // Card byte pointer stays inside the card
    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERASE || r_state == S_STORE || r_state == S_LOAD)
            |-> (r_ptr <= LAST_BYTE))
        else $error("card pointer beyond card size");

endmodule

@@ test/card_access_checker.sv @@
// Checker for the dual-slot memory card controller: predicts read_data per item.
// Holds its own image of the slot registers and both card stores.
// Depends on dsmcc_pkg.
`timescale 1ns / 100ps

module card_access_checker #(
    parameter int CARD_BYTES = dsmcc_pkg::CARD_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic        i_mode,
    input  logic        i_slot,
    input  logic [1:0]  i_reg_select,
    input  logic [31:0] i_write_data,
    input  logic [31:0] i_write_mask,
    input  logic        i_strobe,
    input  logic [31:0] i_read_data,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    logic [31:0] slot_regs [dsmcc_pkg::NUM_REGS];
    logic [7:0]  card_image [2 * CARD_BYTES];
    logic [31:0] pending_read_data [$];
    logic [31:0] oldest;
    int          fail_count;
    int          checked;

    // Apply one access to the image and return the value the block must put out
    function automatic logic [31:0] predict_access(dsmcc_pkg::t_mode mode, logic slot,
                                                   dsmcc_pkg::t_reg_sel sel,
                                                   logic [31:0] wdata, logic [31:0] wmask);
        logic [2:0]  idx;
        logic [31:0] ctl;
        logic [31:0] word;
        int unsigned addr;
        int unsigned blk;
        int unsigned card_base;
        idx = {slot, sel};
        if (mode == dsmcc_pkg::MODE_READ) begin
            return slot_regs[idx];
        end
        slot_regs[idx] = (slot_regs[idx] & ~wmask) | (wdata & wmask);
        if (sel == dsmcc_pkg::REG_CTL) begin
            ctl       = slot_regs[{slot, dsmcc_pkg::REG_CTL}];
            addr      = slot_regs[{slot, dsmcc_pkg::REG_ADDR}] % 32'(CARD_BYTES);
            card_base = slot ? CARD_BYTES : 0;
            if (ctl[dsmcc_pkg::CTL_ERASE]) begin
                blk = addr & ~dsmcc_pkg::ERASE_BASE_MASK;
                for (int i = 0; i < (1 << dsmcc_pkg::ERASE_SPAN_W); i++) begin
                    if (blk + i < CARD_BYTES) begin
                        card_image[card_base + blk + i] = dsmcc_pkg::ERASE_FILL;
                    end
                end
            end
            if (ctl[dsmcc_pkg::CTL_STORE]) begin
                word = slot_regs[{slot, dsmcc_pkg::REG_DATA}];
                for (int i = 0; i < 4; i++) begin
                    card_image[card_base + (addr + i) % CARD_BYTES] = word[8*i +: 8];
                end
            end
            if (ctl[dsmcc_pkg::CTL_LOAD]) begin
                word = '0;
                for (int i = 0; i < 4; i++) begin
                    word[8*i +: 8] = card_image[card_base + (addr + i) % CARD_BYTES];
                end
                slot_regs[{slot, dsmcc_pkg::REG_DATA}] = word;
            end
            slot_regs[{slot, dsmcc_pkg::REG_READY}] = 32'd1;
        end
        return '0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (slot_regs[i]) slot_regs[i] = '0;
            foreach (card_image[i]) card_image[i] = 8'h00;
            pending_read_data.delete();
            fail_count = 0;
            checked    = 0;
        end else begin
            // Compare first: a result at this edge belongs to an older item
            if (i_strobe) begin
                if (pending_read_data.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_read_data);
                    fail_count++;
                end else begin
                    oldest = pending_read_data.pop_front();
                    checked++;
                    if (i_read_data !== oldest) begin
                        $display("%0t: read_data mismatch, expected %h, actual %h",
                                 $time, oldest, i_read_data);
                        fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                pending_read_data.push_back(
                    predict_access(dsmcc_pkg::t_mode'(i_mode), i_slot,
                                   dsmcc_pkg::t_reg_sel'(i_reg_select),
                                   i_write_data, i_write_mask));
            end
        end
        o_fail_count <= fail_count;
        o_pending    <= pending_read_data.size();
        o_checked    <= checked;
    end

endmodule

@@ test/tb.sv @@
// Top of the testbench for the dual-slot memory card controller.
// Drives register accesses and card sequences; card_access_checker does the checking.
// Depends on dsmcc_pkg, card_access_checker and the controller RTL.
`timescale 1ns / 100ps

module tb;

    // The clearing pass after reset is the longest quiet stretch
    localparam int WATCHDOG_LIMIT    = 800_000;
    localparam int RESET_CYCLES      = 7;
    localparam int TOTAL_ITEMS       = 1400;
    // Each erase holds the port while it erases a 64 KiB block; keep them rare
    localparam int MAX_RANDOM_ERASES = 4;
    localparam int DRAIN_CYCLES      = 8;
    localparam int CARD_BYTES        = dsmcc_pkg::CARD_BYTES;
    localparam logic [31:0] DO_STORE       = 32'd1 << dsmcc_pkg::CTL_STORE;
    localparam logic [31:0] DO_LOAD        = 32'd1 << dsmcc_pkg::CTL_LOAD;
    localparam logic [31:0] DO_ERASE       = 32'd1 << dsmcc_pkg::CTL_ERASE;
    localparam logic [31:0] ACTION_BITS    = (32'd1 << dsmcc_pkg::CTL_W) - 32'd1;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        start        = 1'b0;
    logic        busy;
    logic        i_mode       = 1'b0;
    logic        i_slot       = 1'b0;
    logic [1:0]  i_reg_select = 2'd0;
    logic [31:0] i_write_data = '0;
    logic [31:0] i_write_mask = '0;
    logic        o_strobe;
    logic [31:0] o_read_data;

    int fail_count;
    int pending;
    int checked;

    int idle_pct = 0;
    int n_items = 0;
    int n_reads = 0;
    int n_erases = 0;
    int n_random_erases = 0;
    int n_edge_addr = 0;
    int idle_cycles = 0;

    logic                seq_slot;
    logic [31:0]         card_addr;
    logic [31:0]         ctl_word;
    logic [31:0]         addr_pool [8];
    dsmcc_pkg::t_mode    one_mode;
    dsmcc_pkg::t_reg_sel one_sel;
    logic [31:0]         one_data;
    logic [31:0]         one_mask;

    dual_slot_memory_card_controller DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_write_mask (i_write_mask),
        .o_strobe     (o_strobe),
        .o_read_data  (o_read_data)
    );

    card_access_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_reg_select (i_reg_select),
        .i_write_data (i_write_data),
        .i_write_mask (i_write_mask),
        .i_strobe     (o_strobe),
        .i_read_data  (o_read_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hand one item to the block: idle at random first, then hold start
    // until an edge finds busy low
    task automatic issue(input dsmcc_pkg::t_mode mode, input logic slot,
                         input dsmcc_pkg::t_reg_sel sel,
                         input logic [31:0] wdata, input logic [31:0] wmask);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_mode       <= mode;
        i_slot       <= slot;
        i_reg_select <= sel;
        i_write_data <= wdata;
        i_write_mask <= wmask;
        start        <= 1'b1;
        do @(posedge i_clk); while (busy);
        n_items++;
        if (mode == dsmcc_pkg::MODE_READ) n_reads++;
    endtask

    // Favor the extremes so that every mask and data bit sees both values
    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        foreach (addr_pool[i]) addr_pool[i] = $urandom_range(CARD_BYTES - 1);
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, no idling. Registers read back zero after reset.
        issue(dsmcc_pkg::MODE_READ, 1'b0, dsmcc_pkg::REG_CTL, '1, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b1, dsmcc_pkg::REG_READY, '0, '0);
        // Address far past the card end: reduced to the last byte, word wraps to 0..2
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_ADDR, '1, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_DATA, 32'h89AB_CDEF, '1);
        // Zero mask leaves the register alone
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_DATA, '1, '0);
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_CTL, DO_STORE, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_DATA, '0, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_CTL, DO_LOAD, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b0, dsmcc_pkg::REG_DATA, '0, '0);
        issue(dsmcc_pkg::MODE_READ, 1'b0, dsmcc_pkg::REG_READY, '0, '0);
        // Ready is writable; only a control write sets it again
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_READY, '0, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b0, dsmcc_pkg::REG_READY, '0, '0);
        // Control write without action bits writes the register and sets ready, with no card action
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_CTL, ~ACTION_BITS, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b0, dsmcc_pkg::REG_READY, '0, '0);
        issue(dsmcc_pkg::MODE_WRITE, 1'b0, dsmcc_pkg::REG_CTL, '1, '0);
        // Slot 1: store, then erase its 64K block and load the erased word
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_ADDR, 32'h0001_2345, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_DATA, 32'h1357_9BDF, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_CTL, DO_STORE, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_CTL, DO_ERASE | DO_LOAD, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b1, dsmcc_pkg::REG_DATA, '0, '0);
        // All three actions at once, in erase, store, load order
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_ADDR, 32'h0000_0010, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_DATA, 32'h0246_8ACE, '1);
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_CTL,
              DO_ERASE | DO_STORE | DO_LOAD, '1);
        issue(dsmcc_pkg::MODE_READ, 1'b1, dsmcc_pkg::REG_DATA, '0, '0);
        // Drop the erase bit so later control writes cannot repeat it
        issue(dsmcc_pkg::MODE_WRITE, 1'b1, dsmcc_pkg::REG_CTL, '0, '1);
        n_erases    = 2;
        n_edge_addr = 1;

        // Random part: mostly address/data/control sequences, the rest noise
        while (n_items < TOTAL_ITEMS) begin
            case ((n_items / 100) % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 84;
                default: idle_pct = 38;
            endcase
            if ($urandom_range(9) < 6) begin
                seq_slot = 1'($urandom_range(1));
                // Reuse pooled addresses so loads find earlier stores
                case ($urandom_range(9))
                    0, 1, 2, 3, 4: card_addr = addr_pool[3'($urandom_range(7))];
                    5, 6:          card_addr = CARD_BYTES - $urandom_range(4, 1);
                    7:             card_addr = $urandom;
                    default:       card_addr = $urandom_range(CARD_BYTES - 1);
                endcase
                if (card_addr >= CARD_BYTES - 3) n_edge_addr++;
                if ($urandom_range(3) == 0) addr_pool[3'($urandom_range(7))] = card_addr;
                issue(dsmcc_pkg::MODE_WRITE, seq_slot, dsmcc_pkg::REG_ADDR, card_addr, '1);
                if ($urandom_range(1)) begin
                    issue(dsmcc_pkg::MODE_WRITE, seq_slot, dsmcc_pkg::REG_DATA, $urandom,
                          ($urandom_range(7) == 0) ? $urandom : '1);
                end
                // Mask always covers the action bits, so the erase bit is ours to pick
                ctl_word = $urandom;
                ctl_word[dsmcc_pkg::CTL_ERASE] = 1'b0;
                if (n_random_erases < MAX_RANDOM_ERASES && $urandom_range(63) == 0) begin
                    ctl_word[dsmcc_pkg::CTL_ERASE] = 1'b1;
                    n_random_erases++;
                    n_erases++;
                end
                issue(dsmcc_pkg::MODE_WRITE, seq_slot, dsmcc_pkg::REG_CTL, ctl_word,
                      $urandom | ACTION_BITS);
                if ($urandom_range(3) != 0) begin
                    issue(dsmcc_pkg::MODE_READ, seq_slot, dsmcc_pkg::REG_DATA,
                          $urandom, $urandom);
                end
                if ($urandom_range(1)) begin
                    issue(dsmcc_pkg::MODE_READ, seq_slot, dsmcc_pkg::REG_READY,
                          $urandom, $urandom);
                end
                if ($urandom_range(2) == 0) begin
                    issue(dsmcc_pkg::MODE_WRITE, seq_slot, dsmcc_pkg::REG_READY,
                          $urandom, $urandom);
                end
            end else begin
                one_mode = dsmcc_pkg::t_mode'($urandom_range(1));
                one_sel  = dsmcc_pkg::t_reg_sel'($urandom_range(3));
                one_data = pick_word();
                one_mask = pick_word();
                // Hold the erase bit clear on stray control writes
                if (one_mode == dsmcc_pkg::MODE_WRITE && one_sel == dsmcc_pkg::REG_CTL) begin
                    one_mask[dsmcc_pkg::CTL_ERASE] = 1'b1;
                    one_data[dsmcc_pkg::CTL_ERASE] = 1'b0;
                end
                issue(one_mode, 1'($urandom_range(1)), one_sel, one_data, one_mask);
            end
        end
        start <= 1'b0;

        // Drain: sample on the falling edge, clear of the checker's updates
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("Ran %0d items (%0d reads), %0d block erases, %0d addresses near the card end.",
                 n_items, n_reads, n_erases, n_edge_addr);
        $display("Compared %0d results with the predicted register values.", checked);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: count edges where no item is taken and no result appears
    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((start && !busy) || o_strobe) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Watchdog expired at %0t", $time);
        $display("Regression FAIL");
        $finish;
    end

endmodule
